// File: rtl/fuc_pkg.sv
// shared types, constants and crc function for the firmware update controller
package fuc_pkg;

    localparam int CHUNK_BYTES = 4;
    localparam int CHUNK_LANES = (CHUNK_BYTES > 4) ? 4 : CHUNK_BYTES;
    localparam logic [2:0] MAX_LEN = 3'(CHUNK_LANES);

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] REBOOT_DELAY_MS = 32'd250;
    localparam logic [9:0] MS_PER_S = 10'd1000;
    localparam logic [12:0] PAGE_BYTES = 13'd4096;

    // item kinds
    localparam logic [1:0] REQ_DATA = 2'd0;
    localparam logic [1:0] REQ_CMD = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // commands
    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_COMMIT = 3'd2;
    localparam logic [2:0] CMD_ABORT = 3'd3;
    localparam logic [2:0] CMD_ACCEPT = 3'd4;
    localparam logic [2:0] CMD_REBOOT = 3'd5;

    // flash outcome
    localparam logic [1:0] FLASH_OK = 2'd0;
    localparam logic [1:0] FLASH_INVALID = 2'd2;

    // abort codes
    localparam logic [3:0] AB_OK = 4'd0;
    localparam logic [3:0] AB_BAD_STATE = 4'd1;
    localparam logic [3:0] AB_TRANSFER = 4'd2;
    localparam logic [3:0] AB_TOO_LONG = 4'd3;
    localparam logic [3:0] AB_TOO_SHORT = 4'd4;
    localparam logic [3:0] AB_HARDWARE = 4'd5;
    localparam logic [3:0] AB_NO_ROOM = 4'd6;
    localparam logic [3:0] AB_CRC = 4'd7;
    localparam logic [3:0] AB_RANGE = 4'd8;

    // update status
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RECEIVING = 3'd1;
    localparam logic [2:0] ST_ACTIVATED = 3'd2;
    localparam logic [2:0] ST_PENDING = 3'd3;
    localparam logic [2:0] ST_ERR_STATE = 3'd4;
    localparam logic [2:0] ST_ERR_SIZE = 3'd5;
    localparam logic [2:0] ST_ERR_CRC = 3'd6;
    localparam logic [2:0] ST_ERR_FLASH = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMG_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_CRC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROBATION = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] chunk_offset;
        logic [31:0] chunk_bytes;
        logic [2:0]  chunk_len;
        logic        final_chunk;
        logic [2:0]  command;
        logic [31:0] tick_time_ms;
        logic        drive_safe;
        logic [1:0]  flash_result;
    } item_t;

    typedef struct packed {
        logic [3:0]  abort_code;
        logic [2:0]  update_status;
        logic [31:0] byte_count;
        logic        restart_now;
        logic        rollback_now;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } cfg_wr_t;

    function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [31:0] data,
                                                 logic [2:0] len);
        logic [31:0] c;
        c = crc;
        for (int b = 0; b < CHUNK_LANES; b++) begin
            if (3'(b) < len)
            begin
                c = c ^ {24'b0, data[8*b +: 8]};
                for (int k = 0; k < 8; k++) begin
                    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
                end
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/fuc_engine.sv
// session state, configuration registers and per-item update logic
module fuc_engine
    import fuc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_wr_t cfg,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic [31:0] img_len_reg, img_len_next;
    logic [31:0] image_crc_reg, image_crc_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [31:0] slot_size_reg, slot_size_next;

    logic        session_open_reg, session_open_next;
    logic [31:0] written_count_reg, written_count_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic        pending_verify_reg, pending_verify_next;
    logic        reboot_valid_reg, reboot_valid_next;
    logic [31:0] reboot_time_reg, reboot_time_next;
    logic        deadline_valid_reg, deadline_valid_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] current_time_reg, current_time_next;
    logic [2:0]  status_reg, status_next;
    logic [11:0] page_fill_reg, page_fill_next;

    logic [2:0]  len_c;
    logic [32:0] sum_c;
    logic [32:0] limit_c;
    logic [12:0] fill_c;
    logic [11:0] fill_after;
    logic        fail_c;
    logic [25:0] span_c;
    logic [31:0] reboot_diff;
    logic [31:0] deadline_diff;
    logic [3:0]  code_c;
    logic        restart_c;
    logic        rollback_c;
    logic        failed;

    assign len_c = (item.chunk_len > MAX_LEN) ? MAX_LEN : item.chunk_len;
    assign sum_c = {1'b0, written_count_reg} + {30'b0, len_c};
    assign limit_c = {1'b0, (img_len_reg != 32'd0) ? img_len_reg : 32'hFFFF_FFFF};
    assign fill_c = {1'b0, page_fill_reg} + {10'b0, len_c};
    assign fail_c = item.flash_result != FLASH_OK;
    assign span_c = {10'b0, timeout_reg} * {16'b0, MS_PER_S};
    assign reboot_diff = item.tick_time_ms - reboot_time_reg;
    assign deadline_diff = item.tick_time_ms - deadline_reg;

    always_comb
    begin
        img_len_next = img_len_reg;
        image_crc_next = image_crc_reg;
        timeout_next = timeout_reg;
        slot_size_next = slot_size_reg;
        session_open_next = session_open_reg;
        written_count_next = written_count_reg;
        running_crc_next = running_crc_reg;
        pending_verify_next = pending_verify_reg;
        reboot_valid_next = reboot_valid_reg;
        reboot_time_next = reboot_time_reg;
        deadline_valid_next = deadline_valid_reg;
        deadline_next = deadline_reg;
        current_time_next = current_time_reg;
        status_next = status_reg;
        page_fill_next = page_fill_reg;
        code_c = AB_OK;
        restart_c = 1'b0;
        rollback_c = 1'b0;
        failed = 1'b0;
        fill_after = fill_c[11:0];

        if (step)
        begin
            case (item.req_type)
                REQ_DATA:
                begin
                    if (!session_open_reg)
                    begin
                        status_next = ST_ERR_STATE;
                        code_c = AB_BAD_STATE;
                    end
                    else if (item.chunk_offset != written_count_reg)
                    begin
                        status_next = ST_ERR_STATE;
                        code_c = AB_TRANSFER;
                        failed = 1'b1;
                    end
                    else if (sum_c > limit_c)
                    begin
                        status_next = ST_ERR_SIZE;
                        code_c = AB_TOO_LONG;
                        failed = 1'b1;
                    end
                    else
                    begin
                        running_crc_next = crc32_update(running_crc_reg, item.chunk_bytes,
                                                        len_c);
                        written_count_next = sum_c[31:0];
                        // page boundary crossed or partial page flushed
                        if ((fill_c >= PAGE_BYTES) || (item.final_chunk && fill_after != 12'd0))
                        begin
                            if (fail_c)
                            begin
                                status_next = ST_ERR_FLASH;
                                code_c = AB_HARDWARE;
                                failed = 1'b1;
                            end
                            else if (item.final_chunk)
                            begin
                                page_fill_next = 12'd0;
                            end
                            else
                            begin
                                page_fill_next = fill_after;
                            end
                        end
                        else
                        begin
                            page_fill_next = fill_after;
                        end
                    end
                end
                REQ_CMD:
                begin
                    case (item.command)
                        CMD_NONE:
                        begin
                            code_c = AB_OK;
                        end
                        CMD_START:
                        begin
                            if (pending_verify_reg || !item.drive_safe)
                            begin
                                status_next = ST_ERR_STATE;
                                code_c = AB_BAD_STATE;
                            end
                            else if (img_len_reg == 32'd0)
                            begin
                                status_next = ST_ERR_SIZE;
                                code_c = AB_TOO_SHORT;
                            end
                            else
                            begin
                                failed = 1'b1;
                                if (img_len_reg > slot_size_reg)
                                begin
                                    status_next = ST_ERR_SIZE;
                                    code_c = AB_NO_ROOM;
                                end
                                else if (fail_c)
                                begin
                                    status_next = ST_ERR_FLASH;
                                    code_c = AB_HARDWARE;
                                end
                                else
                                begin
                                    failed = 1'b0;
                                    session_open_next = 1'b1;
                                    written_count_next = 32'd0;
                                    page_fill_next = 12'd0;
                                    running_crc_next = CRC_INIT;
                                    status_next = ST_RECEIVING;
                                end
                            end
                        end
                        CMD_COMMIT:
                        begin
                            if (!session_open_reg)
                            begin
                                status_next = ST_ERR_STATE;
                                code_c = AB_BAD_STATE;
                            end
                            else if (written_count_reg != img_len_reg)
                            begin
                                status_next = ST_ERR_SIZE;
                                code_c = AB_TOO_SHORT;
                                failed = 1'b1;
                            end
                            else if ((running_crc_reg ^ CRC_INIT) != image_crc_reg)
                            begin
                                status_next = ST_ERR_CRC;
                                code_c = AB_CRC;
                                failed = 1'b1;
                            end
                            else
                            begin
                                session_open_next = 1'b0;
                                if (fail_c)
                                begin
                                    status_next = (item.flash_result == FLASH_INVALID) ?
                                                  ST_ERR_CRC : ST_ERR_FLASH;
                                    code_c = AB_HARDWARE;
                                end
                                else
                                begin
                                    status_next = ST_ACTIVATED;
                                    reboot_time_next = current_time_reg + REBOOT_DELAY_MS;
                                    reboot_valid_next = 1'b1;
                                end
                            end
                        end
                        CMD_ABORT:
                        begin
                            failed = 1'b1;
                            status_next = ST_IDLE;
                        end
                        CMD_ACCEPT:
                        begin
                            if (!pending_verify_reg)
                            begin
                                status_next = ST_ERR_STATE;
                                code_c = AB_BAD_STATE;
                            end
                            else if (fail_c)
                            begin
                                status_next = ST_ERR_FLASH;
                                code_c = AB_HARDWARE;
                            end
                            else
                            begin
                                pending_verify_next = 1'b0;
                                deadline_valid_next = 1'b0;
                                deadline_next = 32'd0;
                                status_next = ST_IDLE;
                            end
                        end
                        CMD_REBOOT:
                        begin
                            reboot_time_next = current_time_reg + REBOOT_DELAY_MS;
                            reboot_valid_next = 1'b1;
                        end
                        default:
                        begin
                            code_c = AB_RANGE;
                        end
                    endcase
                end
                REQ_TICK:
                begin
                    current_time_next = item.tick_time_ms;
                    if (reboot_valid_reg && !reboot_diff[31])
                    begin
                        restart_c = 1'b1;
                    end
                    else if (pending_verify_reg && timeout_reg != 16'd0)
                    begin
                        if (!deadline_valid_reg)
                        begin
                            deadline_next = item.tick_time_ms + {6'b0, span_c};
                            deadline_valid_next = 1'b1;
                        end
                        else if (!deadline_diff[31])
                        begin
                            rollback_c = 1'b1;
                        end
                    end
                end
                default:
                begin
                    code_c = AB_OK;
                end
            endcase

            // drop the session and start over
            if (failed)
            begin
                session_open_next = 1'b0;
                written_count_next = 32'd0;
                page_fill_next = 12'd0;
                running_crc_next = CRC_INIT;
            end
        end

        if (cfg.we)
        begin
            case (cfg.index)
                REG_IMG_LEN:         img_len_next = cfg.data;
                REG_IMAGE_CRC:       image_crc_next = cfg.data;
                REG_CONFIRM_TIMEOUT: timeout_next = cfg.data[15:0];
                REG_SLOT_SIZE:       slot_size_next = cfg.data;
                REG_PROBATION:
                begin
                    pending_verify_next = cfg.data[0];
                    status_next = cfg.data[0] ? ST_PENDING : ST_IDLE;
                    deadline_valid_next = 1'b0;
                    deadline_next = 32'd0;
                end
                default:
                begin
                    img_len_next = img_len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_len_reg <= 32'd0;
            image_crc_reg <= 32'd0;
            timeout_reg <= 16'd0;
            slot_size_reg <= 32'hFFFF_FFFF;
            session_open_reg <= 1'b0;
            written_count_reg <= 32'd0;
            running_crc_reg <= CRC_INIT;
            pending_verify_reg <= 1'b0;
            reboot_valid_reg <= 1'b0;
            reboot_time_reg <= 32'd0;
            deadline_valid_reg <= 1'b0;
            deadline_reg <= 32'd0;
            current_time_reg <= 32'd0;
            status_reg <= ST_IDLE;
            page_fill_reg <= 12'd0;
        end
        else
        begin
            img_len_reg <= img_len_next;
            image_crc_reg <= image_crc_next;
            timeout_reg <= timeout_next;
            slot_size_reg <= slot_size_next;
            session_open_reg <= session_open_next;
            written_count_reg <= written_count_next;
            running_crc_reg <= running_crc_next;
            pending_verify_reg <= pending_verify_next;
            reboot_valid_reg <= reboot_valid_next;
            reboot_time_reg <= reboot_time_next;
            deadline_valid_reg <= deadline_valid_next;
            deadline_reg <= deadline_next;
            current_time_reg <= current_time_next;
            status_reg <= status_next;
            page_fill_reg <= page_fill_next;
        end
    end

    always_comb
    begin
        result.abort_code = code_c;
        result.update_status = status_next;
        result.byte_count = written_count_next;
        result.restart_now = restart_c;
        result.rollback_now = rollback_c;
    end

endmodule

// File: rtl/firmware_update_controller.sv
// Firmware update controller top level: input register, update engine and result register.
// Every input transfer yields exactly one result transfer. Items pass an input register, the
// session/CRC update logic and a result register, so a result is presented once its item has
// passed both registers and can be taken at the following edge, and one item can be taken
// every cycle; the only stall is back-pressure from the result side, which reaches
// s_axis_tready combinationally. Configuration writes are taken in the cycle they are offered
// (cfg_ready is always high).
module firmware_update_controller
    import fuc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // chunk_offset, chunk_bytes, chunk_len, command, tick_time_ms, drive_safe, flash_result
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [1:0]           s_axis_tuser,
    // final_chunk
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // abort_code, update_status, byte count, restart_now, rollback_now
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg, in_item_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;
    logic    step;
    logic    s_xfer;
    result_t eng_res;
    cfg_wr_t cfg_wr;

    assign step = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_wr.we = cfg_valid;
        cfg_wr.index = cfg_index;
        cfg_wr.data = cfg_data;
    end

    fuc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_wr),
        .step   (step),
        .item   (in_item_reg),
        .result (eng_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next = in_item_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
            in_item_next.req_type = s_axis_tuser;
            in_item_next.chunk_offset = s_axis_tdata[31:0];
            in_item_next.chunk_bytes = s_axis_tdata[63:32];
            in_item_next.chunk_len = s_axis_tdata[66:64];
            in_item_next.final_chunk = s_axis_tlast;
            in_item_next.command = s_axis_tdata[69:67];
            in_item_next.tick_time_ms = s_axis_tdata[101:70];
            in_item_next.drive_safe = s_axis_tdata[102];
            in_item_next.flash_result = s_axis_tdata[104:103];
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next = out_res_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            out_res_next = eng_res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'b0, out_res_reg.rollback_now, out_res_reg.restart_now,
                           out_res_reg.byte_count, out_res_reg.update_status,
                           out_res_reg.abort_code};

`ifndef NO_ASSERTIONS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_res_reg.restart_now && out_res_reg.rollback_now))
        else $error("restart and rollback raised together");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_res_reg.abort_code <= AB_RANGE))
        else $error("abort code out of range");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline is full and stalled");

    a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_axis_tvalid)
        else $error("processed item produced no result");
`endif

endmodule
